// ----- hdl/wbps_pkg.sv -----
package wbps_pkg;

    localparam int MAX_PATTERN_BYTES = 32;
    localparam int POSITION_BITS     = 32;

    localparam int PAT_BYTES         = 32;
    localparam int PAT_IDX_BITS      = 5;
    localparam int LEN_BITS          = 6;
    localparam int OUT_BITS          = 32;
    localparam int APB_ADDR_BITS     = 6;
    localparam int APB_DATA_BITS     = 64;
    localparam int REG_IDX_BITS      = 3;

    localparam logic [REG_IDX_BITS-1:0] REG_PATTERN_0      = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_PATTERN_1      = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_PATTERN_2      = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_PATTERN_3      = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_WILDCARD_MASK  = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_PATTERN_LENGTH = 3'd5;

    typedef struct packed {
        logic [MAX_PATTERN_BYTES-1:0][7:0] pat;
        logic [MAX_PATTERN_BYTES-1:0]      care;
        logic [LEN_BITS-1:0]               len;
    } wbps_cfg_t;

endpackage

// ----- hdl/wbps_in_if.sv -----
interface wbps_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       module_start;

    modport source (output valid, output data_byte, output module_start, input ready);
    modport sink (input valid, input data_byte, input module_start, output ready);
endinterface

// ----- hdl/wbps_out_if.sv -----
interface wbps_out_if;
    logic        valid;
    logic        ready;
    logic        match_found;
    logic [31:0] match_offset;
    logic [31:0] match_count;
    logic [31:0] first_offset;
    logic        first_valid;

    modport source (output valid, output match_found, output match_offset,
                    output match_count, output first_offset, output first_valid,
                    input ready);
    modport sink (input valid, input match_found, input match_offset,
                  input match_count, input first_offset, input first_valid,
                  output ready);
endinterface

// ----- hdl/wbps_cell.sv -----
module wbps_cell
    import wbps_pkg::*;
(
    input  logic       clk,
    input  logic       shift,
    input  logic [7:0] byte_in,
    input  logic [7:0] pat_byte,
    input  logic       care,
    output logic [7:0] byte_out,
    output logic       hit
);

    logic [7:0] hist_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            hist_reg <= byte_in;
        end
    end

    assign byte_out = hist_reg;
    assign hit      = !care || (hist_reg == pat_byte);

endmodule

// ----- hdl/wbps_cfg.sv -----
module wbps_cfg
    import wbps_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output wbps_cfg_t                cfg
);

    logic [3:0][APB_DATA_BITS-1:0] pattern_reg;
    logic [PAT_BYTES-1:0]          wild_reg;
    logic [LEN_BITS-1:0]           len_reg;

    logic [PAT_BYTES-1:0][7:0]     pat_bytes;
    logic [REG_IDX_BITS-1:0]       reg_idx;
    logic                          wr_en;
    logic [LEN_BITS-1:0]           len_eff;

    assign reg_idx   = paddr[APB_ADDR_BITS-1:3];
    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite;
    assign pat_bytes = pattern_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            wild_reg    <= '0;
            len_reg     <= LEN_BITS'(1);
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_PATTERN_0:      pattern_reg[0] <= pwdata;
                REG_PATTERN_1:      pattern_reg[1] <= pwdata;
                REG_PATTERN_2:      pattern_reg[2] <= pwdata;
                REG_PATTERN_3:      pattern_reg[3] <= pwdata;
                REG_WILDCARD_MASK:  wild_reg       <= pwdata[PAT_BYTES-1:0];
                REG_PATTERN_LENGTH: len_reg        <= pwdata[LEN_BITS-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_PATTERN_0:      prdata = pattern_reg[0];
            REG_PATTERN_1:      prdata = pattern_reg[1];
            REG_PATTERN_2:      prdata = pattern_reg[2];
            REG_PATTERN_3:      prdata = pattern_reg[3];
            REG_WILDCARD_MASK:  prdata = APB_DATA_BITS'(wild_reg);
            REG_PATTERN_LENGTH: prdata = APB_DATA_BITS'(len_reg);
            default:            prdata = '0;
        endcase
    end

    // Pattern bytes are lined up by age: entry a holds the byte that must sit a bytes back.
    always_comb
    begin
        logic [LEN_BITS-1:0] src;
        if (len_reg == '0)
        begin
            len_eff = LEN_BITS'(1);
        end
        else if (len_reg > LEN_BITS'(MAX_PATTERN_BYTES))
        begin
            len_eff = LEN_BITS'(MAX_PATTERN_BYTES);
        end
        else
        begin
            len_eff = len_reg;
        end
        cfg.len = len_eff;
        for (int a = 0; a < MAX_PATTERN_BYTES; a++)
        begin
            src = len_eff - LEN_BITS'(a) - LEN_BITS'(1);
            if (LEN_BITS'(a) < len_eff)
            begin
                cfg.pat[a]  = pat_bytes[src[PAT_IDX_BITS-1:0]];
                cfg.care[a] = !wild_reg[src[PAT_IDX_BITS-1:0]];
            end
            else
            begin
                cfg.pat[a]  = 8'd0;
                cfg.care[a] = 1'b0;
            end
        end
    end

endmodule

// ----- hdl/wildcard_byte_pattern_scanner_top.sv -----
// Channel   Role    Payload
// in_ch     sink    data_byte[7:0], module_start
// out_ch    source  match_found, match_offset[31:0], match_count[31:0],
//                   first_offset[31:0], first_valid
// apb       slave   paddr[5:0], pwdata/prdata[63:0], pready tied high
//
// One request per cycle unless stalled; the result is in the output register the next cycle.
// The byte history is a row of shift cells compared in parallel against the pattern.
// A new request is taken whenever the output register is empty or being emptied.
// Reset clears control state and the output valid flag; history and output data need none.
module wildcard_byte_pattern_scanner_top
    import wbps_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    wbps_in_if.sink                  in_ch,
    wbps_out_if.source               out_ch,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    wbps_cfg_t                    cfg;
    logic [7:0]                   hist [MAX_PATTERN_BYTES];
    logic [MAX_PATTERN_BYTES-1:0] hits;

    logic [POSITION_BITS-1:0]     pos_reg, pos_next;
    logic [OUT_BITS-1:0]          cnt_reg, cnt_next;
    logic [OUT_BITS-1:0]          eo_reg, eo_next;
    logic                         ev_reg, ev_next;

    logic                         out_valid_reg;
    logic                         found_reg;
    logic [OUT_BITS-1:0]          off_reg;
    logic [OUT_BITS-1:0]          cnt_out_reg;
    logic [OUT_BITS-1:0]          first_reg;
    logic                         fvalid_reg;

    logic                         accept;
    logic                         start;
    logic [POSITION_BITS-1:0]     idx;
    logic [POSITION_BITS-1:0]     len_m1;
    logic [POSITION_BITS-1:0]     start_off;
    logic                         found;
    logic [OUT_BITS-1:0]          cnt_base;

    wbps_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign accept       = in_ch.valid && in_ch.ready;
    assign in_ch.ready  = !out_valid_reg || out_ch.ready;
    assign start        = in_ch.module_start;

    assign hist[0] = in_ch.data_byte;
    assign hits[0] = !cfg.care[0] || (in_ch.data_byte == cfg.pat[0]);

    for (genvar k = 1; k < MAX_PATTERN_BYTES; k++)
    begin : g_cell
        wbps_cell u_cell (
            .clk      (clk),
            .shift    (accept),
            .byte_in  (hist[k-1]),
            .pat_byte (cfg.pat[k]),
            .care     (cfg.care[k]),
            .byte_out (hist[k]),
            .hit      (hits[k])
        );
    end

    always_comb
    begin
        idx       = start ? '0 : pos_reg;
        len_m1    = POSITION_BITS'(cfg.len - LEN_BITS'(1));
        found     = (idx >= len_m1) && (&hits);
        start_off = idx - len_m1;
        pos_next  = (idx == '1) ? idx : idx + POSITION_BITS'(1);
        cnt_base  = start ? '0 : cnt_reg;
        cnt_next  = (found && cnt_base != '1) ? cnt_base + OUT_BITS'(1) : cnt_base;
        ev_next   = start ? 1'b0 : ev_reg;
        eo_next   = start ? '0 : eo_reg;
        if (found && !ev_next)
        begin
            ev_next = 1'b1;
            eo_next = OUT_BITS'(start_off);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            cnt_reg       <= '0;
            eo_reg        <= '0;
            ev_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                pos_reg       <= pos_next;
                cnt_reg       <= cnt_next;
                eo_reg        <= eo_next;
                ev_reg        <= ev_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            found_reg   <= found;
            off_reg     <= found ? OUT_BITS'(start_off) : '0;
            cnt_out_reg <= cnt_next;
            first_reg   <= ev_next ? eo_next : '0;
            fvalid_reg  <= ev_next;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.match_found  = found_reg;
    assign out_ch.match_offset = off_reg;
    assign out_ch.match_count  = cnt_out_reg;
    assign out_ch.first_offset = first_reg;
    assign out_ch.first_valid  = fvalid_reg;

endmodule
